@@ rtl/mlc_pkg.sv @@
// Shared types and constants for the max line container.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package mlc_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [61:0] icpt;
    } t_line;

    // operands of the exact neighbor test: prev, current, next line
    typedef struct packed {
        logic               start;
        logic signed [31:0] pm;
        logic signed [61:0] pb;
        logic signed [31:0] cm;
        logic signed [61:0] cb;
        logic signed [31:0] nm;
        logic signed [61:0] nb;
    } t_cmp_req;

    typedef struct packed {
        logic done;
        logic ge;
    } t_cmp_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_F_RD, S_F_CHK, S_SH_RD, S_SH_WR,
        S_U_RDC, S_U_RDP, S_U_RDN, S_U_EVAL, S_U_WAIT, S_U_DEC,
        S_RM_RD, S_RM_WR, S_P_SEL,
        S_Q_RD, S_Q_MUL, S_Q_ADD, S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        PH_SELF, PH_AFTER, PH_BEFORE
    } t_phase;

    typedef enum logic [1:0] {
        C_IDLE, C_MUL, C_NEG, C_CMP
    } t_cmp_state;

endpackage

@@ rtl/mlc_line_mem.sv @@
// Line store: one write port, one read port, registered read data.
// Depends on mlc_pkg for the line type.
`timescale 1ns / 1ps

module mlc_line_mem #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  mlc_pkg::t_line  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output mlc_pkg::t_line  o_rdata
);
    import mlc_pkg::*;

    t_line r_mem [CAPACITY];
    t_line r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mlc_cross_cmp.sv @@
// Exact test (pb-cb)*(nm-cm) >= (cb-nb)*(cm-pm) as a sequence of steps,
// using one 31x32 multiplier. Depends on mlc_pkg.
`timescale 1ns / 1ps

module mlc_cross_cmp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlc_pkg::t_cmp_req i_req,
    output mlc_pkg::t_cmp_rsp o_rsp
);
    import mlc_pkg::*;

    t_cmp_state r_state, n_state;
    logic [2:0]  r_step;
    logic [61:0] r_al, r_ar;
    logic [31:0] r_dl, r_dr;
    logic        r_negl, r_negr;
    logic [62:0] r_pp;
    logic [93:0] r_accl, r_accr;
    logic signed [95:0] r_sl, r_sr;
    logic        r_done, r_ge;

    logic signed [62:0] w_al, w_ar;
    logic signed [32:0] w_dl, w_dr;
    logic [30:0] w_ma;
    logic [31:0] w_md;

    assign w_al = 63'(i_req.pb) - 63'(i_req.cb);
    assign w_dl = 33'(i_req.nm) - 33'(i_req.cm);
    assign w_ar = 63'(i_req.cb) - 63'(i_req.nb);
    assign w_dr = 33'(i_req.cm) - 33'(i_req.pm);

    always_comb begin
        case (r_step)
            3'd0:    begin w_ma = r_al[30:0];  w_md = r_dl; end
            3'd1:    begin w_ma = r_al[61:31]; w_md = r_dl; end
            3'd2:    begin w_ma = r_ar[30:0];  w_md = r_dr; end
            default: begin w_ma = r_ar[61:31]; w_md = r_dr; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_req.start) n_state = C_MUL;
            C_MUL:  if (r_step == 3'd4) n_state = C_NEG;
            C_NEG:  n_state = C_CMP;
            C_CMP:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_CMP);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_step <= 3'd0;
                r_accl <= '0;
                r_accr <= '0;
                r_negl <= w_al[62] ^ w_dl[32];
                r_negr <= w_ar[62] ^ w_dr[32];
                r_al   <= w_al[62] ? 62'(-w_al) : w_al[61:0];
                r_ar   <= w_ar[62] ? 62'(-w_ar) : w_ar[61:0];
                r_dl   <= w_dl[32] ? 32'(-w_dl) : w_dl[31:0];
                r_dr   <= w_dr[32] ? 32'(-w_dr) : w_dr[31:0];
            end
            C_MUL: begin
                r_step <= r_step + 3'd1;
                r_pp   <= 63'(w_ma) * 63'(w_md);
                // accumulate the partial product of the previous step
                case (r_step)
                    3'd1:    r_accl <= r_accl + 94'(r_pp);
                    3'd2:    r_accl <= r_accl + {r_pp, 31'd0};
                    3'd3:    r_accr <= r_accr + 94'(r_pp);
                    3'd4:    r_accr <= r_accr + {r_pp, 31'd0};
                    default: ;
                endcase
            end
            C_NEG: begin
                r_sl <= r_negl ? -$signed({2'b00, r_accl}) : $signed({2'b00, r_accl});
                r_sr <= r_negr ? -$signed({2'b00, r_accr}) : $signed({2'b00, r_accr});
            end
            C_CMP: r_ge <= (r_sl >= r_sr);
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ge   = r_ge;

endmodule

@@ rtl/max_line_container_unit.sv @@
// Top level of the max line container: sequencer, line store, neighbor test.
// Depends on mlc_pkg, mlc_line_mem and mlc_cross_cmp.
`timescale 1ns / 1ps

// Keeps the upper envelope of lines slope*x+intercept, sorted by slope, in a
// single-port-read memory of CAPACITY entries. One transaction in gives one
// transaction out (best_value on tdata, status on tuser). Items are handled
// one at a time; the single memory read port sets the cost. A query reads
// every stored line. An insert scans for its place P, shifts the entries
// from P on up to open the gap, reads each neighbor for a test (an exact
// three-line test where both neighbors exist), and moves the entries down
// for each line it prunes.
// A full store rejects an insert at once with status 2.
module max_line_container_unit #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,  // slope[31:0], intercept[93:32], point[125:94]
    input  logic          i_s_axis_tuser,  // command
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,  // best_value[63:0]
    output logic [1:0]    o_m_axis_tuser   // status[1:0]
);
    import mlc_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);
    localparam logic [CW-1:0] One    = CW'(1);

    t_state r_state, n_state;
    t_phase r_phase;

    logic [CW-1:0] r_cnt, r_k, r_pos, r_i;
    logic signed [31:0] r_m, r_x, r_cm, r_pm;
    logic signed [61:0] r_b, r_cb, r_pb, r_qb;
    logic signed [63:0] r_prod, r_best;
    logic          r_first, r_has_prev, r_has_next, r_useless;
    logic [1:0]    r_status;
    logic          r_o_valid;
    logic [63:0]   r_o_value;
    logic [1:0]    r_o_status;

    logic          w_accept, w_out_free;
    logic          w_re, w_we;
    logic [CW-1:0] w_raddr, w_waddr;
    t_line         w_wdata, w_rdata;
    t_cmp_req      w_req;
    t_cmp_rsp      w_rsp;
    logic          w_cmp_start;
    logic signed [63:0] w_prod, w_val;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_o_valid || i_m_axis_tready;

    mlc_line_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    mlc_cross_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_req.start = w_cmp_start;
    assign w_req.pm = r_pm;
    assign w_req.pb = r_pb;
    assign w_req.cm = r_cm;
    assign w_req.cb = r_cb;
    assign w_req.nm = w_rdata.slope;
    assign w_req.nb = w_rdata.icpt;

    assign w_prod = 64'(w_rdata.slope) * 64'(r_x);
    assign w_val  = r_prod + 64'(r_qb);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                if (i_s_axis_tuser == CMD_QUERY)
                    n_state = (r_cnt == '0) ? S_RESULT : S_Q_RD;
                else
                    n_state = (r_cnt == CapCnt) ? S_RESULT : S_F_RD;
            end
            S_F_RD:   n_state = (r_k == r_cnt) ? S_SH_RD : S_F_CHK;
            S_F_CHK:  n_state = (w_rdata.slope > r_m) ? S_SH_RD : S_F_RD;
            S_SH_RD:  n_state = (r_k == r_pos) ? S_U_RDC : S_SH_WR;
            S_SH_WR:  n_state = S_SH_RD;
            S_U_RDC:  n_state = S_U_RDP;
            S_U_RDP:  n_state = S_U_RDN;
            S_U_RDN:  n_state = S_U_EVAL;
            S_U_EVAL: n_state = (r_has_prev && r_has_next) ? S_U_WAIT : S_U_DEC;
            S_U_WAIT: if (w_rsp.done) n_state = S_U_DEC;
            S_U_DEC: begin
                if (r_useless)                n_state = S_RM_RD;
                else if (r_phase == PH_BEFORE) n_state = S_RESULT;
                else                          n_state = S_P_SEL;
            end
            S_RM_RD: begin
                if (r_k + One >= r_cnt)
                    n_state = (r_phase == PH_SELF) ? S_RESULT : S_P_SEL;
                else
                    n_state = S_RM_WR;
            end
            S_RM_WR:  n_state = S_RM_RD;
            S_P_SEL: begin
                if (r_phase == PH_AFTER)
                    n_state = (r_pos + One < r_cnt) ? S_U_RDC : S_P_SEL;
                else if (r_phase == PH_BEFORE)
                    n_state = (r_pos != '0) ? S_U_RDC : S_RESULT;
                else
                    n_state = S_RESULT;
            end
            S_Q_RD:   n_state = (r_k == r_cnt) ? S_RESULT : S_Q_MUL;
            S_Q_MUL:  n_state = S_Q_ADD;
            S_Q_ADD:  n_state = S_Q_RD;
            S_RESULT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory and comparator requests
    always_comb begin
        w_re        = 1'b0;
        w_raddr     = r_k;
        w_we        = 1'b0;
        w_waddr     = r_k;
        w_wdata     = w_rdata;
        w_cmp_start = 1'b0;
        unique case (r_state)
            S_F_RD, S_Q_RD: w_re = (r_k != r_cnt);
            S_SH_RD: begin
                if (r_k == r_pos) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata.slope = r_m;
                    w_wdata.icpt  = r_b;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_k - One;
                end
            end
            S_SH_WR, S_RM_WR: w_we = 1'b1;
            S_U_RDC: begin
                w_re    = 1'b1;
                w_raddr = r_i;
            end
            S_U_RDP: begin
                w_re    = (r_i != '0);
                w_raddr = r_i - One;
            end
            S_U_RDN: begin
                w_re    = r_has_next;
                w_raddr = r_i + One;
            end
            S_U_EVAL: w_cmp_start = r_has_prev && r_has_next;
            S_RM_RD: begin
                w_re    = (r_k + One < r_cnt);
                w_raddr = r_k + One;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SH_RD && r_k == r_pos)
                r_cnt <= r_cnt + One;
            else if (r_state == S_RM_RD && r_k + One >= r_cnt)
                r_cnt <= r_cnt - One;
            if (r_state == S_RESULT && w_out_free)
                r_o_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && w_out_free) begin
            r_o_value  <= r_best;
            r_o_status <= r_status;
        end
        case (r_state)
            S_IDLE: if (w_accept) begin
                r_m      <= i_s_axis_tdata[31:0];
                r_b      <= i_s_axis_tdata[93:32];
                r_x      <= i_s_axis_tdata[125:94];
                r_k      <= '0;
                r_best   <= '0;
                r_first  <= 1'b1;
                r_status <= ST_OK;
                if (i_s_axis_tuser == CMD_QUERY && r_cnt == '0)
                    r_status <= ST_EMPTY;
                if (i_s_axis_tuser == CMD_INSERT && r_cnt == CapCnt)
                    r_status <= ST_FULL;
            end
            S_F_RD: if (r_k == r_cnt) begin
                r_pos <= r_cnt;
                r_k   <= r_cnt;
            end
            S_F_CHK: begin
                if (w_rdata.slope > r_m) begin
                    r_pos <= r_k;
                    r_k   <= r_cnt;
                end else begin
                    r_k <= r_k + One;
                end
            end
            S_SH_RD: if (r_k == r_pos) begin
                r_i     <= r_pos;
                r_phase <= PH_SELF;
            end
            S_SH_WR: r_k <= r_k - One;
            S_U_RDC: begin
                r_has_prev <= (r_i != '0);
                r_has_next <= (r_i + One < r_cnt);
            end
            S_U_RDP: begin
                r_cm <= w_rdata.slope;
                r_cb <= w_rdata.icpt;
            end
            S_U_RDN: begin
                r_pm <= w_rdata.slope;
                r_pb <= w_rdata.icpt;
            end
            S_U_EVAL: begin
                // end lines: useless only against an equal slope neighbor
                if (!r_has_prev)
                    r_useless <= r_has_next && (w_rdata.slope == r_cm)
                                 && (r_cb <= w_rdata.icpt);
                else if (!r_has_next)
                    r_useless <= (r_cm == r_pm) && (r_cb <= r_pb);
            end
            S_U_WAIT: if (w_rsp.done) r_useless <= w_rsp.ge;
            S_U_DEC: begin
                if (r_useless)
                    r_k <= r_i;
                else if (r_phase == PH_SELF)
                    r_phase <= PH_AFTER;
                else if (r_phase == PH_AFTER)
                    r_phase <= PH_BEFORE;
            end
            S_RM_RD: begin
                if (r_k + One >= r_cnt && r_phase == PH_BEFORE)
                    r_pos <= r_pos - One;
            end
            S_RM_WR: r_k <= r_k + One;
            S_P_SEL: begin
                if (r_phase == PH_AFTER) begin
                    if (r_pos + One < r_cnt) r_i <= r_pos + One;
                    else                     r_phase <= PH_BEFORE;
                end else if (r_phase == PH_BEFORE) begin
                    if (r_pos != '0) r_i <= r_pos - One;
                end
            end
            S_Q_MUL: begin
                r_prod <= w_prod;
                r_qb   <= w_rdata.icpt;
            end
            S_Q_ADD: begin
                if (r_first || w_val > r_best)
                    r_best <= w_val;
                r_first <= 1'b0;
                r_k     <= r_k + One;
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_value;
    assign o_m_axis_tuser  = r_o_status;

endmodule
